// ===== src/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrd_pkg: shared types and codes for the history ring
// Record, request, result and command types, opcodes and status codes.
// ----------------------------------------------------------------------------
package hrd_pkg;

   typedef logic [63:0]        key_type;
   typedef logic [15:0]        ses_type;
   typedef logic signed [31:0] code_type;
   typedef logic [8:0]         cnt_type;
   typedef logic [63:0]        word_type;
   typedef logic [2:0]         op_type;
   typedef logic [1:0]         status_type;

   localparam op_type OP_APPEND = 3'd0;
   localparam op_type OP_READ   = 3'd1;
   localparam op_type OP_PREV   = 3'd2;
   localparam op_type OP_NEXT   = 3'd3;
   localparam op_type OP_CLEAR  = 3'd4;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_INVALID   = 2'd2;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      key_type  cmd;
      ses_type  ses;
      logic     done;
      code_type code;
      word_type seq;
   } rec_type;

   typedef struct packed {
      op_type   opcode;
      key_type  command_key;
      ses_type  session_key;
      logic     completed;
      code_type ret_code;
      cnt_type  position;
   } req_type;

   typedef struct packed {
      status_type status;
      cnt_type    cursor_out;
      key_type    entry_command_key;
      ses_type    entry_session_key;
      logic       entry_completed;
      code_type   entry_ret_code;
      word_type   entry_sequence;
      cnt_type    entries_held;
      word_type   appended_total;
      word_type   succeeded_total;
      word_type   failed_total;
      word_type   revision_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } hrd_cmd_type;

endpackage

// ===== src/hrd_if.sv =====
// ----------------------------------------------------------------------------
// hrd_if: request and response channels
// Valid/ready channels carrying the request and result fields.
// ----------------------------------------------------------------------------
interface hrd_req_if;
   logic                valid;
   logic                ready;
   hrd_pkg::op_type     opcode;
   hrd_pkg::key_type    command_key;
   hrd_pkg::ses_type    session_key;
   logic                completed;
   hrd_pkg::code_type   ret_code;
   hrd_pkg::cnt_type    position;

   modport source (output valid, opcode, command_key, session_key, completed,
                   ret_code, position, input ready);
   modport sink   (input valid, opcode, command_key, session_key, completed,
                   ret_code, position, output ready);
endinterface

interface hrd_rsp_if;
   logic                 valid;
   logic                 ready;
   hrd_pkg::status_type  status;
   hrd_pkg::cnt_type     cursor_out;
   hrd_pkg::key_type     entry_command_key;
   hrd_pkg::ses_type     entry_session_key;
   logic                 entry_completed;
   hrd_pkg::code_type    entry_ret_code;
   hrd_pkg::word_type    entry_sequence;
   hrd_pkg::cnt_type     entries_held;
   hrd_pkg::word_type    appended_total;
   hrd_pkg::word_type    succeeded_total;
   hrd_pkg::word_type    failed_total;
   hrd_pkg::word_type    revision_total;

   modport source (output valid, status, cursor_out, entry_command_key,
                   entry_session_key, entry_completed, entry_ret_code,
                   entry_sequence, entries_held, appended_total,
                   succeeded_total, failed_total, revision_total,
                   input ready);
   modport sink   (input valid, status, cursor_out, entry_command_key,
                   entry_session_key, entry_completed, entry_ret_code,
                   entry_sequence, entries_held, appended_total,
                   succeeded_total, failed_total, revision_total,
                   output ready);
endinterface

// ===== src/hrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrd_ctrl: history ring controller
// Two-state sequencer: capture a request with its slot read, then commit
// the result into the output register once that register is free.
// ----------------------------------------------------------------------------
module hrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hrd_pkg::hrd_cmd_type cmd
);
   import hrd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            // hold while the previous result still waits
            cmd.commit = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EXEC)
      else $error("capture did not enter execute");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && rsp_valid_ff && !rsp_ready) |=> state_ff == S_EXEC)
      else $error("left execute while output was blocked");

endmodule

// ===== src/hrd_dpath.sv =====
// ----------------------------------------------------------------------------
// hrd_dpath: history ring datapath
// Slot memory, ring pointers, statistics counters and the result register.
// ----------------------------------------------------------------------------
module hrd_dpath #(
   parameter int DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hrd_pkg::hrd_cmd_type cmd,
   input  hrd_pkg::req_type     req_data,
   input  logic                 csr_wr_en,
   input  hrd_pkg::cnt_type     csr_wr_data,
   output hrd_pkg::rsp_type     rsp_data
);
   import hrd_pkg::*;

   localparam int      AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam cnt_type CAP_LIM = (DEPTH > 511) ? 9'd511 : 9'(DEPTH);
   localparam cnt_type CAP_RST = (DEPTH > 256) ? 9'd256 : 9'(DEPTH);

   rec_type mem [DEPTH];

   rec_type          rd_data_ff;
   logic [AW-1:0]    rd_addr_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   cnt_type          cap_ff, cap_in;
   cnt_type          held_ff, held_in;
   cnt_type          oldest_ff, oldest_in;
   word_type         seq_ff, seq_in;
   word_type         app_ff, app_in;
   word_type         suc_ff, suc_in;
   word_type         fail_ff, fail_in;
   word_type         rev_ff, rev_in;

   logic [9:0]       rd_idx;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   rec_type          wr_rec;
   logic             fold;
   cnt_type          clamp_pos;

   // logical index to physical slot, wrap by compare and subtract
   function automatic logic [AW-1:0] phys(input logic [9:0] idx,
                                          input cnt_type oldest,
                                          input cnt_type cap);
      logic [10:0] p;
      logic [31:0] pw;
      p = 11'(oldest) + 11'(idx);
      if (p >= 11'(cap)) p = p - 11'(cap);
      pw = 32'(p);
      if (pw >= DEPTH) pw = '0;
      return pw[AW-1:0];
   endfunction

   assign clamp_pos = (req_data.position > held_ff) ? held_ff : req_data.position;

   always_comb begin
      case (req_data.opcode)
         OP_APPEND: rd_idx = 10'(held_ff) - 10'd1;
         OP_READ:   rd_idx = 10'(req_data.position);
         OP_PREV:   rd_idx = 10'(clamp_pos) - 10'd1;
         OP_NEXT:   rd_idx = 10'(req_data.position) + 10'd1;
         default:   rd_idx = '0;
      endcase
      rd_addr = phys(rd_idx, oldest_ff, cap_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
         req_ff     <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_rec;
   end

   assign fold = (held_ff != '0) && (rd_data_ff.cmd == req_ff.command_key) &&
                 (rd_data_ff.ses == req_ff.session_key);

   always_comb begin
      cnt_type c;
      c         = (req_ff.position > held_ff) ? held_ff : req_ff.position;
      held_in   = held_ff;
      oldest_in = oldest_ff;
      seq_in    = seq_ff;
      app_in    = app_ff;
      suc_in    = suc_ff;
      fail_in   = fail_ff;
      rev_in    = rev_ff;
      wr_en     = 1'b0;
      wr_addr   = rd_addr_ff;
      wr_rec    = '{cmd: req_ff.command_key, ses: req_ff.session_key,
                    done: req_ff.completed, code: req_ff.ret_code, seq: seq_ff};
      rsp_in            = '0;
      rsp_in.status     = STATUS_OK;
      rsp_in.cursor_out = req_ff.position;
      case (req_ff.opcode)
         OP_APPEND: begin
            if (req_ff.command_key == '0) begin
               rsp_in.status = STATUS_INVALID;
            end else begin
               wr_en = cmd.commit;
               if (!fold) begin
                  if (held_ff >= cap_ff) begin
                     // full: overwrite the oldest and advance the head
                     wr_addr   = phys(10'd0, oldest_ff, cap_ff);
                     oldest_in = (oldest_ff + 9'd1 >= cap_ff) ? '0 : oldest_ff + 9'd1;
                  end else begin
                     wr_addr = phys(10'(held_ff), oldest_ff, cap_ff);
                     held_in = held_ff + 9'd1;
                  end
               end
               seq_in = seq_ff + 64'd1;
               app_in = app_ff + 64'd1;
               rev_in = rev_ff + 64'd1;
               if (req_ff.completed && req_ff.ret_code == '0) suc_in = suc_ff + 64'd1;
               if (req_ff.completed && req_ff.ret_code != '0) fail_in = fail_ff + 64'd1;
            end
         end
         OP_READ: begin
            if (req_ff.position >= held_ff) rsp_in.status = STATUS_NOT_FOUND;
            else begin
               rsp_in.entry_command_key = rd_data_ff.cmd;
               rsp_in.entry_session_key = rd_data_ff.ses;
               rsp_in.entry_completed   = rd_data_ff.done;
               rsp_in.entry_ret_code    = rd_data_ff.code;
               rsp_in.entry_sequence    = rd_data_ff.seq;
            end
         end
         OP_PREV: begin
            if (held_ff == '0) rsp_in.status = STATUS_NOT_FOUND;
            else if (c == '0) begin
               rsp_in.status     = STATUS_NOT_FOUND;
               rsp_in.cursor_out = '0;
            end else begin
               rsp_in.cursor_out        = c - 9'd1;
               rsp_in.entry_command_key = rd_data_ff.cmd;
               rsp_in.entry_session_key = rd_data_ff.ses;
               rsp_in.entry_completed   = rd_data_ff.done;
               rsp_in.entry_ret_code    = rd_data_ff.code;
               rsp_in.entry_sequence    = rd_data_ff.seq;
            end
         end
         OP_NEXT: begin
            if (10'(req_ff.position) + 10'd1 >= 10'(held_ff)) begin
               rsp_in.status     = STATUS_NOT_FOUND;
               rsp_in.cursor_out = held_ff;
            end else begin
               rsp_in.cursor_out        = req_ff.position + 9'd1;
               rsp_in.entry_command_key = rd_data_ff.cmd;
               rsp_in.entry_session_key = rd_data_ff.ses;
               rsp_in.entry_completed   = rd_data_ff.done;
               rsp_in.entry_ret_code    = rd_data_ff.code;
               rsp_in.entry_sequence    = rd_data_ff.seq;
            end
         end
         OP_CLEAR: begin
            held_in   = '0;
            oldest_in = '0;
            rev_in    = rev_ff + 64'd1;
         end
         default: rsp_in.status = STATUS_INVALID;
      endcase
      rsp_in.entries_held    = held_in;
      rsp_in.appended_total  = app_in;
      rsp_in.succeeded_total = suc_in;
      rsp_in.failed_total    = fail_in;
      rsp_in.revision_total  = rev_in;
   end

   always_comb begin
      if (csr_wr_data == '0) cap_in = 9'd1;
      else if (csr_wr_data > CAP_LIM) cap_in = CAP_LIM;
      else cap_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RST;
         held_ff   <= '0;
         oldest_ff <= '0;
         seq_ff    <= 64'd1;
         app_ff    <= '0;
         suc_ff    <= '0;
         fail_ff   <= '0;
         rev_ff    <= '0;
      end else if (csr_wr_en) begin
         // new capacity empties the ring, counters stay
         cap_ff    <= cap_in;
         held_ff   <= '0;
         oldest_ff <= '0;
      end else if (cmd.commit) begin
         held_ff   <= held_in;
         oldest_ff <= oldest_in;
         seq_ff    <= seq_in;
         app_ff    <= app_in;
         suc_ff    <= suc_in;
         fail_ff   <= fail_in;
         rev_ff    <= rev_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_held_le_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff)
      else $error("ring holds more entries than its capacity");

   a_head_in_ring: assert property (@(posedge clock) disable iff (reset)
      oldest_ff < cap_ff)
      else $error("head slot outside the ring");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && req_ff.opcode == OP_CLEAR) |=> held_ff == '0)
      else $error("clear left entries behind");

endmodule

// ===== src/history_ring_with_dedup.sv =====
// ----------------------------------------------------------------------------
// history_ring_with_dedup: overwriting command history ring
// Append with folding of a repeat of the newest record, indexed read,
// cursor steps, clear, and running statistics on every result.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one operation per transfer (append, read, previous,
//   next, clear); rsp_ch returns exactly one result per request, in order.
//   csr_wr_en/csr_wr_data set the ring capacity while the block is idle;
//   a write empties the ring but keeps counters and sequence numbers.
//   A request is taken only while the block is idle: the first step reads
//   the newest or addressed slot, the second compares, writes back and
//   registers the result, so a new request waits until the last one is
//   committed.
//   When rsp_ch stalls, one further request is taken and held in the
//   execute step until the output register frees.
//   Reset empties the ring, zeroes the counters and sets the next
//   sequence number to one; capacity returns to min(256, DEPTH). Slot
//   contents are not cleared, and only slots written since the last
//   emptying are ever read.
// ----------------------------------------------------------------------------
module history_ring_with_dedup #(
   parameter int DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   hrd_req_if.sink          req_ch,
   hrd_rsp_if.source        rsp_ch,
   input  logic             csr_wr_en,
   input  hrd_pkg::cnt_type csr_wr_data
);
   import hrd_pkg::*;

   hrd_cmd_type cmd;
   req_type     req_data;
   rsp_type     rsp_data;

   assign req_data = '{opcode:      req_ch.opcode,
                       command_key: req_ch.command_key,
                       session_key: req_ch.session_key,
                       completed:   req_ch.completed,
                       ret_code:    req_ch.ret_code,
                       position:    req_ch.position};

   hrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   hrd_dpath #(.DEPTH(DEPTH)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

   assign rsp_ch.status            = rsp_data.status;
   assign rsp_ch.cursor_out        = rsp_data.cursor_out;
   assign rsp_ch.entry_command_key = rsp_data.entry_command_key;
   assign rsp_ch.entry_session_key = rsp_data.entry_session_key;
   assign rsp_ch.entry_completed   = rsp_data.entry_completed;
   assign rsp_ch.entry_ret_code    = rsp_data.entry_ret_code;
   assign rsp_ch.entry_sequence    = rsp_data.entry_sequence;
   assign rsp_ch.entries_held      = rsp_data.entries_held;
   assign rsp_ch.appended_total    = rsp_data.appended_total;
   assign rsp_ch.succeeded_total   = rsp_data.succeeded_total;
   assign rsp_ch.failed_total      = rsp_data.failed_total;
   assign rsp_ch.revision_total    = rsp_data.revision_total;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for history_ring_with_dedup
// Drives request transfers with random gaps and result stalls and predicts
// every result from a behavioral copy of the ring: folding into the newest
// record, overwrite of the oldest, cursor steps, clear and counters.
// Capacity changes only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
   import hrd_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 19;
   localparam int PRINT_LIMIT = 30;

   // opcodes the block must reject
   localparam op_type OP_UNUSED_LO  = 3'd5;
   localparam op_type OP_UNUSED_MID = 3'd6;
   localparam op_type OP_UNUSED_HI  = 3'd7;

   logic    clock;
   logic    reset;
   logic    csr_wr_en;
   cnt_type csr_wr_data;

   hrd_req_if req_ch ();
   hrd_rsp_if rsp_ch ();

   history_ring_with_dedup #(
      .DEPTH (RING_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted ring contents and counters
   rec_type     ring_rec [RING_DEPTH];
   int unsigned ring_head;
   int unsigned ring_count;
   int unsigned ring_cap;
   word_type    seq_next;
   word_type    n_appended;
   word_type    n_succeeded;
   word_type    n_failed;
   word_type    n_revisions;

   rsp_type     awaited_rsp [$];
   key_type     key_pool [8];
   int unsigned mismatches;
   int unsigned cycles;
   int unsigned requests_sent;
   int unsigned folds_seen;
   int unsigned overwrites_seen;
   int unsigned settings_used;
   bit          steady;
   bit          req_active;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   function automatic int unsigned ring_slot(int unsigned idx);
      int unsigned p;
      p = ring_head + idx;
      if (p >= ring_cap) p -= ring_cap;
      if (p >= RING_DEPTH) p = 0;
      return p;
   endfunction

   function automatic rsp_type with_entry(rsp_type o, int unsigned p);
      o.entry_command_key = ring_rec[p].cmd;
      o.entry_session_key = ring_rec[p].ses;
      o.entry_completed   = ring_rec[p].done;
      o.entry_ret_code    = ring_rec[p].code;
      o.entry_sequence    = ring_rec[p].seq;
      return o;
   endfunction

   function automatic void apply_capacity(cnt_type value);
      if (value == 0) begin
         ring_cap = 1;
      end else if (value > RING_DEPTH) begin
         ring_cap = RING_DEPTH;
      end else begin
         ring_cap = 32'(value);
      end
      ring_count = 0;
      ring_head  = 0;
   endfunction

   function automatic void record_append(req_type r);
      int unsigned p;
      bit          fold;
      p    = 0;
      fold = 1'b0;
      if (ring_count > 0) begin
         p    = ring_slot(ring_count - 1);
         fold = (ring_rec[p].cmd == r.command_key) && (ring_rec[p].ses == r.session_key);
      end
      if (fold) begin
         folds_seen++;
      end else if (ring_count >= ring_cap) begin
         // full: overwrite the oldest and advance the head
         p = ring_head;
         ring_head++;
         if (ring_head >= ring_cap) ring_head -= ring_cap;
         overwrites_seen++;
      end else begin
         p = ring_slot(ring_count);
         ring_count++;
      end
      ring_rec[p] = '{cmd: r.command_key, ses: r.session_key, done: r.completed,
                      code: r.ret_code, seq: seq_next};
      seq_next++;
      n_appended++;
      if (r.completed && r.ret_code == 0) n_succeeded++;
      if (r.completed && r.ret_code != 0) n_failed++;
      n_revisions++;
   endfunction

   function automatic rsp_type predict_result(req_type r);
      rsp_type     o;
      int unsigned pos;
      int unsigned cur;
      o        = '0;
      o.status = STATUS_OK;
      pos      = 32'(r.position);
      cur      = pos;
      case (r.opcode)
         OP_APPEND: begin
            if (r.command_key == '0) o.status = STATUS_INVALID;
            else record_append(r);
         end
         OP_READ: begin
            if (pos >= ring_count) o.status = STATUS_NOT_FOUND;
            else o = with_entry(o, ring_slot(pos));
         end
         OP_PREV: begin
            if (ring_count == 0) begin
               o.status = STATUS_NOT_FOUND;
            end else begin
               if (cur > ring_count) cur = ring_count;
               if (cur == 0) begin
                  o.status = STATUS_NOT_FOUND;
               end else begin
                  cur--;
                  o = with_entry(o, ring_slot(cur));
               end
            end
         end
         OP_NEXT: begin
            if (cur + 1 >= ring_count) begin
               cur      = ring_count;
               o.status = STATUS_NOT_FOUND;
            end else begin
               cur++;
               o = with_entry(o, ring_slot(cur));
            end
         end
         OP_CLEAR: begin
            ring_count = 0;
            ring_head  = 0;
            n_revisions++;
         end
         default: begin
            o.status = STATUS_INVALID;
         end
      endcase
      o.cursor_out      = cnt_type'(cur);
      o.entries_held    = cnt_type'(ring_count);
      o.appended_total  = n_appended;
      o.succeeded_total = n_succeeded;
      o.failed_total    = n_failed;
      o.revision_total  = n_revisions;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, word_type got, word_type want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
   endtask

   task automatic compare_result(rsp_type got, rsp_type want);
      if (got.status !== want.status)
         report_mismatch("status", word_type'(got.status), word_type'(want.status));
      if (got.cursor_out !== want.cursor_out)
         report_mismatch("cursor_out", word_type'(got.cursor_out),
                         word_type'(want.cursor_out));
      if (got.entry_command_key !== want.entry_command_key)
         report_mismatch("entry_command_key", got.entry_command_key, want.entry_command_key);
      if (got.entry_session_key !== want.entry_session_key)
         report_mismatch("entry_session_key", word_type'(got.entry_session_key),
                         word_type'(want.entry_session_key));
      if (got.entry_completed !== want.entry_completed)
         report_mismatch("entry_completed", word_type'(got.entry_completed),
                         word_type'(want.entry_completed));
      if (got.entry_ret_code !== want.entry_ret_code)
         report_mismatch("entry_ret_code", word_type'(got.entry_ret_code),
                         word_type'(want.entry_ret_code));
      if (got.entry_sequence !== want.entry_sequence)
         report_mismatch("entry_sequence", got.entry_sequence, want.entry_sequence);
      if (got.entries_held !== want.entries_held)
         report_mismatch("entries_held", word_type'(got.entries_held),
                         word_type'(want.entries_held));
      if (got.appended_total !== want.appended_total)
         report_mismatch("appended_total", got.appended_total, want.appended_total);
      if (got.succeeded_total !== want.succeeded_total)
         report_mismatch("succeeded_total", got.succeeded_total, want.succeeded_total);
      if (got.failed_total !== want.failed_total)
         report_mismatch("failed_total", got.failed_total, want.failed_total);
      if (got.revision_total !== want.revision_total)
         report_mismatch("revision_total", got.revision_total, want.revision_total);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = '{status: rsp_ch.status, cursor_out: rsp_ch.cursor_out,
                 entry_command_key: rsp_ch.entry_command_key,
                 entry_session_key: rsp_ch.entry_session_key,
                 entry_completed: rsp_ch.entry_completed,
                 entry_ret_code: rsp_ch.entry_ret_code,
                 entry_sequence: rsp_ch.entry_sequence,
                 entries_held: rsp_ch.entries_held,
                 appended_total: rsp_ch.appended_total,
                 succeeded_total: rsp_ch.succeeded_total,
                 failed_total: rsp_ch.failed_total,
                 revision_total: rsp_ch.revision_total};
         if (awaited_rsp.size() == 0)
            report_mismatch("unexpected result", word_type'(got.status), '0);
         else compare_result(got, awaited_rsp.pop_front());
      end
   end

   // result side stalls at random unless a steady stretch is running
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding", awaited_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------
   // drop valid after the last transfer before any other wait
   task automatic hold_requests();
      if (req_active) begin
         req_ch.valid <= 1'b0;
         req_active = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic send_request(req_type r);
      int unsigned gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         hold_requests();
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= r.opcode;
      req_ch.command_key <= r.command_key;
      req_ch.session_key <= r.session_key;
      req_ch.completed   <= r.completed;
      req_ch.ret_code    <= r.ret_code;
      req_ch.position    <= r.position;
      req_active = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      awaited_rsp.push_back(predict_result(r));
      requests_sent++;
   endtask

   task automatic send_op(op_type op, key_type k, ses_type s, logic d, code_type c,
                          cnt_type p);
      send_request('{opcode: op, command_key: k, session_key: s, completed: d,
                     ret_code: c, position: p});
   endtask

   task automatic write_capacity(cnt_type value);
      hold_requests();
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_capacity(value);
      settings_used++;
   endtask

   function automatic req_type make_request(int unsigned append_pct, int unsigned fold_pct,
                                            bit allow_clear);
      req_type     r;
      rec_type     newest;
      int unsigned roll;
      int unsigned sub;
      int unsigned lim;
      r.opcode      = OP_READ;
      r.command_key = {$urandom, $urandom};
      r.session_key = ses_type'($urandom);
      r.completed   = 1'($urandom_range(1));
      r.ret_code    = code_type'($urandom);
      lim  = (ring_count + 1 > RING_DEPTH) ? RING_DEPTH : ring_count + 1;
      roll = $urandom_range(99);
      if (roll < 60) begin
         r.position = cnt_type'($urandom_range(lim));
      end else if (roll < 80) begin
         r.position = (ring_count > 0 && $urandom_range(1) == 1) ?
                      cnt_type'(ring_count - 1) : cnt_type'(ring_count);
      end else begin
         r.position = cnt_type'($urandom_range(RING_DEPTH));
      end
      roll = $urandom_range(99);
      if (roll < append_pct) begin
         r.opcode = OP_APPEND;
         sub = $urandom_range(99);
         if (ring_count > 0 && sub < fold_pct) begin
            // repeat the newest record so it folds
            newest        = ring_rec[ring_slot(ring_count - 1)];
            r.command_key = newest.cmd;
            r.session_key = newest.ses;
         end else if (sub < fold_pct + 10) begin
            r.command_key = '1;
         end else if (sub < fold_pct + 45) begin
            r.command_key = key_pool[$urandom_range(7)];
            r.session_key = ses_type'($urandom_range(3));
         end
         if (r.command_key == '0) r.command_key = 64'd1;
         sub = $urandom_range(99);
         if (sub < 45) r.ret_code = 0;
         else if (sub < 55) r.ret_code = -1;
         else if (sub < 60) r.ret_code = 32'sh8000_0000;
         else if (sub < 65) r.ret_code = 32'sh7fff_ffff;
      end else begin
         sub = $urandom_range(99);
         if (sub < 35) begin
            r.opcode = OP_READ;
         end else if (sub < 55) begin
            r.opcode = OP_PREV;
         end else if (sub < 75) begin
            r.opcode = OP_NEXT;
         end else if (sub < 83 && allow_clear) begin
            r.opcode = OP_CLEAR;
         end else if (sub < 90) begin
            r.opcode      = OP_APPEND;
            r.command_key = '0;
         end else begin
            r.opcode = op_type'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_empty_ring();
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_PREV, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_PREV, '0, '0, 1'b0, 0, 9'd256);
      send_op(OP_NEXT, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_APPEND, '0, 16'hffff, 1'b1, 0, 9'd0);
      send_op(OP_UNUSED_LO, '1, '0, 1'b0, 0, 9'd0);
      send_op(OP_UNUSED_MID, '1, '0, 1'b0, 0, 9'd0);
      send_op(OP_UNUSED_HI, '1, '0, 1'b0, 0, 9'd0);
   endtask

   task automatic test_append_fold();
      send_op(OP_APPEND, '1, 16'hffff, 1'b1, 0, 9'd256);
      // same command and session: replace in place
      send_op(OP_APPEND, '1, 16'hffff, 1'b1, -1, 9'd0);
      send_op(OP_APPEND, 64'd1, 16'h0000, 1'b0, 32'sh7fff_ffff, 9'd0);
      send_op(OP_APPEND, 64'd1, 16'h0001, 1'b1, 32'sh8000_0000, 9'd0);
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd2);
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd3);
      send_op(OP_PREV, '0, '0, 1'b0, 0, 9'd256);
      send_op(OP_NEXT, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_NEXT, '0, '0, 1'b0, 0, 9'd2);
      send_op(OP_CLEAR, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd0);
   endtask

   task automatic test_capacity_limits();
      write_capacity(9'd0);
      send_op(OP_APPEND, 64'd7, 16'd1, 1'b1, 0, 9'd0);
      send_op(OP_APPEND, 64'd8, 16'd1, 1'b1, 0, 9'd0);
      send_op(OP_PREV, '0, '0, 1'b0, 0, 9'd1);
      write_capacity(9'd3);
      send_op(OP_APPEND, 64'd9, 16'd2, 1'b0, 0, 9'd0);
      send_op(OP_APPEND, 64'd10, 16'd2, 1'b1, 5, 9'd0);
      send_op(OP_APPEND, 64'd11, 16'd2, 1'b1, 0, 9'd0);
      send_op(OP_APPEND, 64'd12, 16'd2, 1'b1, 0, 9'd0);
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd0);
      send_op(OP_NEXT, '0, '0, 1'b0, 0, 9'd1);
      // above the ring size: limited to the full depth, ring emptied
      write_capacity(9'd511);
      send_op(OP_READ, '0, '0, 1'b0, 0, 9'd0);
   endtask

   task automatic test_random_traffic(cnt_type cap, int unsigned count, int unsigned append_pct,
                                      int unsigned fold_pct, bit allow_clear, bit no_idle);
      int unsigned i;
      write_capacity(cap);
      steady = no_idle;
      for (i = 0; i < count; i++) begin
         if (i == count / 2) begin
            // let everything drain mid-phase
            hold_requests();
            wait_drained();
         end
         send_request(make_request(append_pct, fold_pct, allow_clear));
      end
      steady = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_APPEND;
      req_ch.command_key = '0;
      req_ch.session_key = '0;
      req_ch.completed   = 1'b0;
      req_ch.ret_code    = '0;
      req_ch.position    = '0;
      ring_head          = 0;
      ring_count         = 0;
      ring_cap           = RING_DEPTH;
      seq_next           = 64'd1;
      n_appended         = '0;
      n_succeeded        = '0;
      n_failed           = '0;
      n_revisions        = '0;
      foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom} | 64'd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_ring();
      test_append_fold();
      test_capacity_limits();
      // full depth with mostly fresh appends so the ring wraps
      test_random_traffic(9'd256, 360, 97, 5, 1'b0, 1'b0);
      test_random_traffic(9'd1, 40, 50, 25, 1'b1, 1'b0);
      test_random_traffic(9'd7, 120, 55, 25, 1'b1, 1'b1);
      test_random_traffic(cnt_type'($urandom_range(255, 2)), 80, 55, 20, 1'b1, 1'b0);

      hold_requests();
      wait_drained();
      repeat (8) @(posedge clock);
      $display("%0d requests over %0d capacity settings, with stalls on both sides",
               requests_sent, settings_used);
      $display("%0d appends folded into the newest record, %0d overwrote the oldest",
               folds_seen, overwrites_seen);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
